### hdl/cma_pkg.sv
`default_nettype none

package cma_pkg;

   // fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int AVG_W      = 8;
   localparam int WLEN_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // parameter defaults
   localparam int STORE_DEPTH_DEF  = 32;
   localparam int SAMPLE_LIMIT_DEF = 100;

   // register indexes and reset values
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_WINDOW_LENGTH = 1'd0;
   localparam csr_idx_type REG_CLAMP_NONNEG  = 1'd1;
   localparam logic [WLEN_W-1:0] WLEN_RESET  = 5'd16;

   // microprogram addresses
   typedef logic [2:0] upc_type;
   localparam upc_type UPC_IDLE   = 3'd0;
   localparam upc_type UPC_WRITE  = 3'd1;
   localparam upc_type UPC_READ   = 3'd2;
   localparam upc_type UPC_DRAIN  = 3'd3;
   localparam upc_type UPC_DIVSET = 3'd4;
   localparam upc_type UPC_DIV    = 3'd5;
   localparam upc_type UPC_DONE   = 3'd6;

   // jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_MORE_TAPS,
      COND_MORE_BITS,
      COND_OUT_BUSY
   } cond_type;

   // one control word
   typedef struct packed {
      logic     req_rdy;
      logic     wr_store;
      logic     rd_store;
      logic     cnt_clr;
      logic     cnt_inc;
      logic     div_init;
      logic     div_step;
      logic     rsp_load;
      cond_type cond;
      upc_type  jump_to;
      upc_type  next_to;
   } ucode_type;

   // control store: taken jump when cond holds, else next_to
   function automatic ucode_type ucode(input upc_type upc);
      ucode_type w;
      w = '0;
      w.cond    = COND_ALWAYS;
      w.jump_to = UPC_IDLE;
      w.next_to = UPC_IDLE;
      unique case (upc)
         UPC_IDLE: begin
            w.req_rdy = 1'b1;
            w.cond    = COND_NO_REQ;
            w.jump_to = UPC_IDLE;
            w.next_to = UPC_WRITE;
         end
         UPC_WRITE: begin
            w.wr_store = 1'b1;
            w.cnt_clr  = 1'b1;
            w.jump_to  = UPC_READ;
            w.next_to  = UPC_READ;
         end
         UPC_READ: begin
            w.rd_store = 1'b1;
            w.cnt_inc  = 1'b1;
            w.cond     = COND_MORE_TAPS;
            w.jump_to  = UPC_READ;
            w.next_to  = UPC_DRAIN;
         end
         UPC_DRAIN: begin
            w.jump_to = UPC_DIVSET;
            w.next_to = UPC_DIVSET;
         end
         UPC_DIVSET: begin
            w.div_init = 1'b1;
            w.cnt_clr  = 1'b1;
            w.jump_to  = UPC_DIV;
            w.next_to  = UPC_DIV;
         end
         UPC_DIV: begin
            w.div_step = 1'b1;
            w.cnt_inc  = 1'b1;
            w.cond     = COND_MORE_BITS;
            w.jump_to  = UPC_DIV;
            w.next_to  = UPC_DONE;
         end
         UPC_DONE: begin
            w.rsp_load = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.jump_to  = UPC_DONE;
            w.next_to  = UPC_IDLE;
         end
         default: begin
            w.jump_to = UPC_IDLE;
            w.next_to = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hdl/cma_ifs.sv
`default_nettype none

// input channel: one raw sample per word
interface cma_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [cma_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// result channel: one average per word
interface cma_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cma_pkg::AVG_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

`default_nettype wire

### hdl/clamped_moving_average_core.sv
`default_nettype none

// Moving average over a ring of clamped samples. Each input word is clamped to
// -SAMPLE_LIMIT..SAMPLE_LIMIT (or 0..SAMPLE_LIMIT when clamp_nonneg is set),
// written at the ring's write index, and answered with one result word: the
// sum of ring entries 0 through length-1 divided by the length, truncated
// toward zero, low 8 bits. A window_length of 0 acts as 1, and one of
// STORE_DEPTH or more as STORE_DEPTH-1; changing it moves no data. A short
// microprogram runs the block one word at a time: a taken word is written to
// the ring, the ring is read and summed, the divider yields MAGW quotient
// bits, where MAGW = clog2(SAMPLE_LIMIT+1) + clog2(STORE_DEPTH) is the width
// of the sum magnitude, and the result is loaded before the next word is
// taken. Ring reads go one entry a cycle through its single read port, and
// the divider produces one quotient bit a cycle. A finished result sits in an
// output register, so the next word is taken while it waits. Register writes
// are taken whenever csr_we is high and belong to idle periods.
module clamped_moving_average_core #(
   parameter int STORE_DEPTH  = cma_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_LIMIT = cma_pkg::SAMPLE_LIMIT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cma_req_if.sink                                 req_bus,
   cma_rsp_if.source                               rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [cma_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cma_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // derived widths
   localparam int SW    = $clog2(SAMPLE_LIMIT + 1) + 1;
   localparam int LW    = $clog2(STORE_DEPTH);
   localparam int SUMW  = SW + LW;
   localparam int MAGW  = SUMW - 1;
   localparam int CNT_W = ($clog2(MAGW) > LW) ? $clog2(MAGW) : LW;
   localparam int RW    = (MAGW > cma_pkg::AVG_W) ? MAGW : cma_pkg::AVG_W;
   localparam int XW    = cma_pkg::SAMPLE_W + 1;
   localparam logic signed [XW-1:0] LIM_POS = XW'(SAMPLE_LIMIT);
   localparam logic signed [XW-1:0] LIM_NEG = -LIM_POS;

   // configuration registers
   logic [cma_pkg::WLEN_W-1:0] wlen_ff, wlen_in;
   logic                       nonneg_ff, nonneg_in;

   // sequencer and datapath registers
   cma_pkg::upc_type           upc_ff, upc_in;
   cma_pkg::ucode_type         ctl;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [LW-1:0]              widx_ff, widx_in;
   logic [LW-1:0]              len_ff, len_in;
   logic [SW-1:0]              samp_ff, samp_in;
   logic [STORE_DEPTH-1:0]     valid_ff, valid_in;
   logic                       pend_ff, pend_in;
   logic                       vld_rd_ff, vld_rd_in;
   logic signed [SUMW-1:0]     sum_ff, sum_in;
   logic [MAGW-1:0]            quo_ff, quo_in;
   logic [LW:0]                rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cma_pkg::AVG_W-1:0]  avg_ff, avg_in;

   // combinational helpers
   logic                       accept;
   logic                       out_busy;
   logic                       cond_hit;
   logic                       rsp_load;
   logic [LW-1:0]              len_eff;
   logic signed [XW-1:0]       samp_ext;
   logic signed [XW-1:0]       samp_clamp;
   logic [LW:0]                widx_inc;
   logic [SW-1:0]              rd_data;
   logic [LW:0]                trial;
   logic signed [SUMW-1:0]     sum_abs;
   logic [RW-1:0]              quo_ext;
   logic [RW-1:0]              avg_wide;

   // ring store
   cma_ram #(
      .WIDTH (SW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.wr_store),
      .wr_addr (widx_ff),
      .wr_data (samp_ff),
      .rd_en   (ctl.rd_store),
      .rd_addr (cnt_ff[LW-1:0]),
      .rd_data (rd_data)
   );

   // control word fetch and handshake
   assign ctl           = cma_pkg::ucode(upc_ff);
   assign req_bus.ready = ctl.req_rdy;
   assign accept        = req_bus.valid && ctl.req_rdy;
   assign out_busy      = rsp_valid_ff && !rsp_bus.ready;
   assign rsp_load      = ctl.rsp_load && !out_busy;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.average = avg_ff;

   // jump condition select
   always_comb begin
      unique case (ctl.cond)
         cma_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         cma_pkg::COND_NO_REQ:    cond_hit = !req_bus.valid;
         cma_pkg::COND_MORE_TAPS: cond_hit = cnt_ff != (CNT_W'(len_ff) - CNT_W'(1));
         cma_pkg::COND_MORE_BITS: cond_hit = cnt_ff != CNT_W'(MAGW - 1);
         cma_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
         default:                 cond_hit = 1'b0;
      endcase
   end

   // effective length and clamp
   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(wlen_ff) >= 32'(STORE_DEPTH)) begin
         len_eff = LW'(STORE_DEPTH - 1);
      end else begin
         len_eff = LW'(wlen_ff);
      end
      samp_ext = {req_bus.sample[cma_pkg::SAMPLE_W-1], req_bus.sample};
      if (samp_ext > LIM_POS) begin
         samp_clamp = LIM_POS;
      end else if (nonneg_ff && samp_ext < 0) begin
         samp_clamp = '0;
      end else if (samp_ext < LIM_NEG) begin
         samp_clamp = LIM_NEG;
      end else begin
         samp_clamp = samp_ext;
      end
   end

   // datapath next state
   always_comb begin
      wlen_in      = wlen_ff;
      nonneg_in    = nonneg_ff;
      upc_in       = cond_hit ? ctl.jump_to : ctl.next_to;
      cnt_in       = cnt_ff;
      widx_in      = widx_ff;
      len_in       = len_ff;
      samp_in      = samp_ff;
      valid_in     = valid_ff;
      pend_in      = ctl.rd_store;
      vld_rd_in    = valid_ff[cnt_ff[LW-1:0]];
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      widx_inc     = {1'b0, widx_ff} + (LW+1)'(1);
      trial        = {rem_ff[LW-1:0], quo_ff[MAGW-1]};
      sum_abs      = sum_ff[SUMW-1] ? -sum_ff : sum_ff;
      quo_ext      = RW'(quo_ff);
      avg_wide     = neg_ff ? -quo_ext : quo_ext;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            cma_pkg::REG_WINDOW_LENGTH: wlen_in   = csr_wdata;
            cma_pkg::REG_CLAMP_NONNEG:  nonneg_in = csr_wdata[0];
            default: ;
         endcase
      end

      // take a word
      if (accept) begin
         samp_in = samp_clamp[SW-1:0];
         len_in  = len_eff;
      end

      // step counter
      if (ctl.cnt_clr) begin
         cnt_in = '0;
      end else if (ctl.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      // store write and index wrap
      if (ctl.wr_store) begin
         valid_in[widx_ff] = 1'b1;
         widx_in = (widx_inc >= {1'b0, len_ff}) ? '0 : widx_inc[LW-1:0];
         sum_in  = '0;
      end

      // accumulate the word read last cycle
      if (pend_ff && vld_rd_ff) begin
         sum_in = sum_ff + {{(SUMW-SW){rd_data[SW-1]}}, rd_data};
      end

      // divider setup and one quotient bit per step
      if (ctl.div_init) begin
         quo_in = sum_abs[MAGW-1:0];
         rem_in = '0;
         neg_in = sum_ff[SUMW-1];
      end else if (ctl.div_step) begin
         if (trial >= {1'b0, len_ff}) begin
            rem_in = trial - {1'b0, len_ff};
            quo_in = {quo_ff[MAGW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[MAGW-2:0], 1'b0};
         end
      end

      // output register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         avg_in       = avg_wide[cma_pkg::AVG_W-1:0];
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= cma_pkg::WLEN_RESET;
         nonneg_ff    <= 1'b0;
         upc_ff       <= cma_pkg::UPC_IDLE;
         widx_ff      <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlen_ff      <= wlen_in;
         nonneg_ff    <= nonneg_in;
         upc_ff       <= upc_in;
         widx_ff      <= widx_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      len_ff    <= len_in;
      samp_ff   <= samp_in;
      vld_rd_ff <= vld_rd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
   end

   // a taken word always goes on to the store write
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> upc_ff == cma_pkg::UPC_WRITE)
      else $error("accepted word did not start the store write");

   // read data only lands right after a ring read step
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(upc_ff) == cma_pkg::UPC_READ)
      else $error("accumulate outside the ring read loop");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      upc_ff == cma_pkg::UPC_DIV |-> rem_ff < {1'b0, len_ff})
      else $error("divider remainder out of range");

endmodule

`default_nettype wire

### hdl/cma_ram.sv
`default_nettype none

module cma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### verif/clamped_moving_average_core_test.sv
module clamped_moving_average_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W         = cma_pkg::SAMPLE_W;
   localparam int AVG_W            = cma_pkg::AVG_W;
   localparam int WLEN_W           = cma_pkg::WLEN_W;
   localparam int CSR_DATA_W       = cma_pkg::CSR_DATA_W;
   localparam int RING_DEPTH       = cma_pkg::STORE_DEPTH_DEF;
   localparam int LIMIT            = cma_pkg::SAMPLE_LIMIT_DEF;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 80;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_WORDS      = 50;
   localparam int HOLD_PHASE       = 2;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   cma_pkg::csr_idx_type  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cma_req_if req_bus ();
   cma_rsp_if rsp_bus ();

   clamped_moving_average_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 100 MHz clock
   always #5 clock = ~clock;

   // filter model: ring contents, write position and register copies
   int                ring [RING_DEPTH];
   int unsigned       ring_wr_pos;
   logic [WLEN_W-1:0] window_len_cfg;
   logic              clamp_cfg;

   // samples waiting to be sent and averages waiting to arrive
   logic signed [SAMPLE_W-1:0] raw_samples [$];
   logic signed [AVG_W-1:0]    expected_averages [$];

   int   send_gap;
   int   recv_gap;
   logic quiet;
   logic long_hold_go;
   logic rsp_hold;
   int   failures;
   int   samples_fed;
   int   averages_checked;
   int   settings_used;

   // clamp, store, advance the ring and average the window
   function automatic logic signed [AVG_W-1:0] filter_average(
      input logic signed [SAMPLE_W-1:0] raw
   );
      int s;
      int n;
      int acc;
      s = raw;
      n = window_len_cfg;
      if (n < 1) n = 1;
      if (n >= RING_DEPTH) n = RING_DEPTH - 1;
      if (s > LIMIT) s = LIMIT;
      if (clamp_cfg) begin
         if (s < 0) s = 0;
      end else begin
         if (s < -LIMIT) s = -LIMIT;
      end
      ring[ring_wr_pos % RING_DEPTH] = s;
      ring_wr_pos = (ring_wr_pos % RING_DEPTH) + 1;
      // a shrunk window sends the position back to the start
      if (ring_wr_pos >= n) ring_wr_pos = 0;
      acc = 0;
      for (int i = 0; i < n; i++) acc += ring[i];
      return AVG_W'(acc / n);
   endfunction

   // mostly small values near the clamp limits, some full range, some extremes
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 7))
         0, 1: s = SAMPLE_W'($urandom());
         2: begin
            case ($urandom_range(0, 7))
               0: s = 16'sh7fff;
               1: s = 16'sh8000;
               2: s = SAMPLE_W'(LIMIT);
               3: s = SAMPLE_W'(LIMIT + 1);
               4: s = SAMPLE_W'(-LIMIT);
               5: s = SAMPLE_W'(-LIMIT - 1);
               6: s = 0;
               default: s = -1;
            endcase
         end
         default: s = SAMPLE_W'(int'($urandom_range(0, 240)) - 120);
      endcase
      return s;
   endfunction

   task automatic offer(input int s);
      raw_samples.push_back(SAMPLE_W'(s));
   endtask

   // register write, only issued while the filter is idle
   task automatic write_reg(input cma_pkg::csr_idx_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == cma_pkg::REG_WINDOW_LENGTH) window_len_cfg = value[WLEN_W-1:0];
      else clamp_cfg = value[0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // checked between edges so all driven values have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (raw_samples.size() != 0 || req_bus.valid || expected_averages.size() != 0);
   endtask

   // driver: offers queued samples with random gaps, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_averages.push_back(filter_average(req_bus.sample));
            samples_fed++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // word still pending, hold it
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (raw_samples.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid  <= 1'b1;
               req_bus.sample <= raw_samples.pop_front();
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: compares each average word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_averages.size() == 0) begin
               $error("average word with nothing expected: got %0d", rsp_bus.average);
               failures++;
            end else begin
               if (rsp_bus.average !== expected_averages[0]) begin
                  $error("average mismatch: expected %0d, got %0d",
                         expected_averages[0], rsp_bus.average);
                  failures++;
               end
               void'(expected_averages.pop_front());
               averages_checked++;
            end
         end
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 18) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold so the filter fills up and stalls its input
   initial begin
      rsp_hold = 1'b0;
      wait (long_hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // run time limit
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus: directed corners, then random phases with fresh settings
   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = cma_pkg::REG_WINDOW_LENGTH;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.sample   = '0;
      rsp_bus.ready    = 1'b0;
      quiet            = 1'b0;
      long_hold_go     = 1'b0;
      failures         = 0;
      samples_fed      = 0;
      averages_checked = 0;
      settings_used    = 1;
      window_len_cfg   = cma_pkg::WLEN_RESET;
      clamp_cfg        = 1'b0;
      ring_wr_pos      = 0;
      foreach (ring[i]) ring[i] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full-scale inputs and both clamp limits
      offer(16'sh7fff);
      offer(16'sh8000);
      offer(LIMIT + 1);
      offer(-LIMIT - 1);
      offer(LIMIT);
      offer(-LIMIT);
      offer(0);
      offer(16'shaaaa);
      offer(16'sh5555);
      wait_drained();

      // non-negative clamp, mode written with upper bits set
      write_reg(cma_pkg::REG_CLAMP_NONNEG, 5'b11111);
      settings_used++;
      offer(16'sh8000);
      offer(-1);
      offer(16'sh7fff);
      offer(50);
      wait_drained();

      // zero length acts as one; mode bit cleared with upper bits set
      write_reg(cma_pkg::REG_CLAMP_NONNEG, 5'b11110);
      write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd0);
      settings_used++;
      offer(80);
      offer(-60);
      wait_drained();

      // longest window
      write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd31);
      settings_used++;
      offer(90);
      offer(-LIMIT);
      offer(16'sh7fff);
      offer(16'sh8000);
      offer(33);
      offer(-7);
      wait_drained();

      // window shrunk below the write position: write lands, position wraps
      write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd3);
      settings_used++;
      offer(42);
      offer(-5);
      offer(12);
      wait_drained();

      // random phases, each with its own settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd0);
            1: write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd1);
            2: write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd31);
            3: write_reg(cma_pkg::REG_WINDOW_LENGTH, 5'd2);
            default: write_reg(cma_pkg::REG_WINDOW_LENGTH,
                               CSR_DATA_W'($urandom_range(0, 31)));
         endcase
         write_reg(cma_pkg::REG_CLAMP_NONNEG, CSR_DATA_W'($urandom_range(0, 31)));
         settings_used++;
         if (p == HOLD_PHASE) long_hold_go = 1'b1;
         if (p == RANDOM_PHASES - 1) quiet = 1'b1;
         for (int k = 0; k < PHASE_WORDS; k++) offer(pick_sample());
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_averages.size() != 0) failures++;

      $display("fed %0d samples under %0d filter settings, checked %0d averages",
               samples_fed, settings_used, averages_checked);
      $display("covered clamp limits in both modes, window lengths 0 to 31, shrink wrap");
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
